// ----- src/cba_pkg.sv -----
// Shared types, constants and command structures for the block automaton.
// Used by the controller, the datapath and the top level; depends on nothing.
package cba_pkg;

    // Grid geometry; the side is even so that rows pair up into two banks.
    localparam int GRID_SIDE = 256;
    localparam int HALF_SIDE = GRID_SIDE / 2;
    localparam int PAIR_W    = $clog2(HALF_SIDE);
    localparam int COL_W     = $clog2(GRID_SIDE);
    localparam int ROW_W     = 8;
    localparam int GEN_W     = 32;

    // Request codes.
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_FWD   = 2'd1;
    localparam logic [1:0] REQ_BWD   = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // One input item.
    typedef struct packed {
        logic [1:0]       req_type;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] col;
        logic             cell_value;
    } cba_req_t;

    // One result item.
    typedef struct packed {
        logic                    alive;
        logic signed [GEN_W-1:0] step_count;
    } cba_rsp_t;

    // Commands from the controller to the datapath, decoded from the current state.
    typedef struct packed {
        logic              clear;    // write zeros to both banks at pair
        logic              accept;   // latch the request, update the counter
        logic              cell_rd;  // read the addressed row
        logic              step_rd;  // read the row pair given by pair
        logic              finish;   // finish cell write-back, present result
        logic [PAIR_W-1:0] pair;
    } cba_cmd_t;

endpackage

// ----- src/cba_ctrl.sv -----
// Controller state machine for the block automaton: clearing pass, cell
// access and the sweep over row pairs. Depends on cba_pkg.
module cba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        req_type,
    output logic              busy,
    output logic              done,
    output cba_pkg::cba_cmd_t cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CELL   = 3'd2;
    localparam logic [2:0] ST_STEP   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    localparam logic [cba_pkg::PAIR_W-1:0] LAST_PAIR =
        cba_pkg::PAIR_W'(cba_pkg::HALF_SIDE - 1);

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [cba_pkg::PAIR_W-1:0]  cnt_reg;
    logic [cba_pkg::PAIR_W-1:0]  cnt_next;

    // State and pair counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.pair   = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (cnt_reg == LAST_PAIR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = '0;
                    if (req_type == cba_pkg::REQ_FWD || req_type == cba_pkg::REQ_BWD)
                    begin
                        state_next = ST_STEP;
                    end
                    else
                    begin
                        state_next = ST_CELL;
                    end
                end
            end
            ST_CELL:
            begin
                cmd.cell_rd = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_STEP:
            begin
                cmd.step_rd = 1'b1;
                if (cnt_reg == LAST_PAIR)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_FINISH);

endmodule

// ----- src/cba_datapath.sv -----
// Datapath of the block automaton: two row banks (even and odd rows), the
// block update logic, the step counter and the result. Depends on cba_pkg.
module cba_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  cba_pkg::cba_cmd_t cmd,
    input  cba_pkg::cba_req_t request,
    output cba_pkg::cba_rsp_t result
);

    localparam int N = cba_pkg::GRID_SIDE;

    // Updates one pair of rows as a row of 2x2 blocks. With shift set the
    // blocks start at column one and the last block wraps round the edge.
    function automatic logic [2*N-1:0] cba_evolve(
        input logic [N-1:0] top,
        input logic [N-1:0] bot,
        input logic         shift,
        input logic         odd
    );
        logic [N-1:0] ts;
        logic [N-1:0] bs;
        logic [N-1:0] nt;
        logic [N-1:0] nb;
        logic [N-1:0] ot;
        logic [N-1:0] ob;
        logic         a;
        logic         b;
        logic         d;
        logic         e;
        logic [2:0]   sum;
        ts = shift ? {top[0], top[N-1:1]} : top;
        bs = shift ? {bot[0], bot[N-1:1]} : bot;
        nt = ts;
        nb = bs;
        for (int i = 0; i < N / 2; i++)
        begin
            a   = ts[2*i];
            b   = ts[2*i+1];
            d   = bs[2*i];
            e   = bs[2*i+1];
            sum = {2'b00, a} + {2'b00, b} + {2'b00, d} + {2'b00, e};
            if (sum == 3'd2)
            begin
                nt[2*i]   = ~a;
                nt[2*i+1] = ~b;
                nb[2*i]   = ~d;
                nb[2*i+1] = ~e;
            end
            else if ((sum == 3'd1 || sum == 3'd3) && (odd ^ (sum == 3'd3)))
            begin
                // Half turn: each diagonal pair trades places.
                nt[2*i]   = e;
                nb[2*i+1] = a;
                nb[2*i]   = b;
                nt[2*i+1] = d;
            end
        end
        ot = shift ? {nt[N-2:0], nt[N-1]} : nt;
        ob = shift ? {nb[N-2:0], nb[N-1]} : nb;
        return {ob, ot};
    endfunction

    // Row banks: even rows and odd rows, one row word per entry.
    logic [N-1:0] even_mem [cba_pkg::HALF_SIDE];
    logic [N-1:0] odd_mem  [cba_pkg::HALF_SIDE];

    cba_pkg::cba_req_t           req_reg;
    logic [cba_pkg::GEN_W-1:0]   gen_reg;
    logic [cba_pkg::GEN_W-1:0]   gen_next;
    logic                        odd_reg;
    logic                        odd_next;
    logic                        wvalid_reg;
    logic [cba_pkg::PAIR_W-1:0]  wpair_reg;
    logic [N-1:0]                rd_even_reg;
    logic [N-1:0]                rd_odd_reg;

    logic [cba_pkg::PAIR_W-1:0]  rd_even_addr;
    logic [cba_pkg::PAIR_W-1:0]  rd_odd_addr;
    logic                        rd_en;
    logic [cba_pkg::PAIR_W-1:0]  wpair_inc;
    logic [cba_pkg::PAIR_W-1:0]  pair_inc;
    logic                        shift;
    logic [2*N-1:0]              evolved;
    logic [N-1:0]                new_top;
    logic [N-1:0]                new_bot;
    logic [N-1:0]                cell_word;
    logic [N-1:0]                patched;
    logic [cba_pkg::COL_W-1:0]   col_idx;
    logic                        in_grid;
    logic                        even_we;
    logic                        odd_we;
    logic [cba_pkg::PAIR_W-1:0]  even_waddr;
    logic [cba_pkg::PAIR_W-1:0]  odd_waddr;
    logic [N-1:0]                even_wdata;
    logic [N-1:0]                odd_wdata;

    // Offset of the block grid: zero on odd parity, one on even parity.
    assign shift = ~odd_reg;

    // Request latch and step counter update on a transfer.
    always_comb
    begin
        gen_next = gen_reg;
        odd_next = odd_reg;
        if (cmd.accept)
        begin
            unique case (request.req_type)
                cba_pkg::REQ_WRITE: gen_next = '0;
                cba_pkg::REQ_FWD:
                begin
                    gen_next = gen_reg + 1'b1;
                    odd_next = ~gen_reg[0];
                end
                cba_pkg::REQ_BWD:
                begin
                    gen_next = gen_reg - 1'b1;
                    odd_next = gen_reg[0];
                end
                cba_pkg::REQ_READ: gen_next = gen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg    <= '0;
            odd_reg    <= 1'b0;
            wvalid_reg <= 1'b0;
        end
        else
        begin
            gen_reg    <= gen_next;
            odd_reg    <= odd_next;
            wvalid_reg <= cmd.step_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
        end
        if (cmd.step_rd)
        begin
            wpair_reg <= cmd.pair;
        end
    end

    // Read addressing: a cell access reads its row in both banks; a sweep
    // reads the pair, the lower row coming from the next even entry when
    // the blocks are offset.
    assign pair_inc = (cmd.pair == cba_pkg::PAIR_W'(cba_pkg::HALF_SIDE - 1))
                      ? '0 : cmd.pair + 1'b1;
    assign rd_en    = cmd.cell_rd | cmd.step_rd;

    always_comb
    begin
        if (cmd.cell_rd)
        begin
            rd_even_addr = req_reg.row[cba_pkg::ROW_W-1:1];
            rd_odd_addr  = req_reg.row[cba_pkg::ROW_W-1:1];
        end
        else
        begin
            rd_even_addr = shift ? pair_inc : cmd.pair;
            rd_odd_addr  = cmd.pair;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_even_reg <= even_mem[rd_even_addr];
            rd_odd_reg  <= odd_mem[rd_odd_addr];
        end
    end

    // Block update on the pair read in the previous cycle.
    assign evolved = shift ? cba_evolve(rd_odd_reg, rd_even_reg, shift, odd_reg)
                           : cba_evolve(rd_even_reg, rd_odd_reg, shift, odd_reg);
    assign new_top = evolved[N-1:0];
    assign new_bot = evolved[2*N-1:N];
    assign wpair_inc = (wpair_reg == cba_pkg::PAIR_W'(cba_pkg::HALF_SIDE - 1))
                       ? '0 : wpair_reg + 1'b1;

    // Cell access: pick the row word and patch the addressed bit.
    assign in_grid   = (int'(req_reg.row) < cba_pkg::GRID_SIDE)
                       && (int'(req_reg.col) < cba_pkg::GRID_SIDE);
    assign col_idx   = req_reg.col[cba_pkg::COL_W-1:0];
    assign cell_word = req_reg.row[0] ? rd_odd_reg : rd_even_reg;

    always_comb
    begin
        patched          = cell_word;
        patched[col_idx] = req_reg.cell_value;
    end

    // Write port selection for both banks.
    always_comb
    begin
        even_we    = 1'b0;
        odd_we     = 1'b0;
        even_waddr = cmd.pair;
        odd_waddr  = cmd.pair;
        even_wdata = '0;
        odd_wdata  = '0;
        if (cmd.clear)
        begin
            even_we = 1'b1;
            odd_we  = 1'b1;
        end
        else if (wvalid_reg)
        begin
            even_we = 1'b1;
            odd_we  = 1'b1;
            if (shift)
            begin
                odd_waddr  = wpair_reg;
                odd_wdata  = new_top;
                even_waddr = wpair_inc;
                even_wdata = new_bot;
            end
            else
            begin
                even_waddr = wpair_reg;
                even_wdata = new_top;
                odd_waddr  = wpair_reg;
                odd_wdata  = new_bot;
            end
        end
        else if (cmd.finish && req_reg.req_type == cba_pkg::REQ_WRITE && in_grid)
        begin
            even_waddr = req_reg.row[cba_pkg::ROW_W-1:1];
            odd_waddr  = req_reg.row[cba_pkg::ROW_W-1:1];
            even_wdata = patched;
            odd_wdata  = patched;
            even_we    = ~req_reg.row[0];
            odd_we     = req_reg.row[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (even_we)
        begin
            even_mem[even_waddr] <= even_wdata;
        end
        if (odd_we)
        begin
            odd_mem[odd_waddr] <= odd_wdata;
        end
    end

    // Result fields, valid while the controller presents the result.
    assign result.alive      = (req_reg.req_type == cba_pkg::REQ_READ) && in_grid
                               && cell_word[col_idx];
    assign result.step_count = gen_reg;

endmodule

// ----- src/critters_block_automaton.sv -----
// Top level of the Critters block cellular automaton.
// Joins cba_ctrl and cba_datapath; depends on cba_pkg.
//
// Usage
//   A request is transferred at a rising edge where start is high and busy is
//   low. Its fields (req_type, row, col, cell_value) arrive as one packed
//   struct on request. Every request yields exactly one result on result,
//   marked by done for exactly one cycle; the receiver cannot stall it.
//   result.step_count is the step counter after the request; result.alive
//   is the addressed cell on a read and zero otherwise.
// Sequencing
//   Cell write and cell read: after the transfer the controller passes through
//   its cell and finish states, with done high in the finish state, and then
//   returns to idle, where a new request can be taken.
//   Forward or backward step: the grid is held as two banks of row words,
//   even and odd rows, and the sweep handles one pair of rows per cycle;
//   after the last pair done is raised in the finish state, and the block
//   then returns to idle.
// Reset
//   After rst_n rises the block runs a clearing pass over all GRID_SIDE/2
//   row pairs that zeroes both banks; busy stays high through it. The step
//   counter resets to zero.
module critters_block_automaton (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cba_pkg::cba_req_t request,
    output logic              done,
    output cba_pkg::cba_rsp_t result
);

    cba_pkg::cba_cmd_t cmd;

    // Sequencing.
    cba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (request.req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd)
    );

    // Storage and block update.
    cba_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .result  (result)
    );

    // A result only follows a cycle in which the block was busy.
    a_done_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n) done |-> $past(busy)
    ) else $error("result strobe without preceding work");

    // A transfer makes the block busy in the next cycle.
    a_accept_busy: assert property (
        @(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy
    ) else $error("transfer did not start work");

    // The result strobe lasts one cycle and the block is free after it.
    a_done_single: assert property (
        @(posedge clk) disable iff (!rst_n) done |=> (!done && !busy)
    ) else $error("result strobe longer than one cycle");

    // A write request always reports a zero step count.
    a_write_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type == cba_pkg::REQ_WRITE)
        |=> ##1 (done && result.step_count == 0)
    ) else $error("cell write did not clear the step counter");

endmodule
